@@ hw/rtl/tip_pkg.sv @@
// Shared types, codes and sizes for the table interpolator.
package tip_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

  localparam int SAMPLE_W  = 24;
  localparam int ACTION_W  = 2;
  localparam int EIDX_W    = 10;
  localparam int POS_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam int IDX_CMP_W = ((ADDR_W > EIDX_W) ? ADDR_W : EIDX_W) + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    JOB_WRITE  = 2'd0,
    JOB_READ   = 2'd1,
    JOB_LOOKUP = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    MODE_TRUNC  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_QUAD   = 2'd2
  } interp_mode_t;

  typedef struct packed {
    job_kind_t          kind;
    interp_mode_t       mode;
    logic [ADDR_W-1:0]  addr0;
    logic [ADDR_W-1:0]  addr1;
    logic [ADDR_W-1:0]  addr2;
    logic [FRAC_W-1:0]  frac;
    sample_t            value;
  } tip_job_t;

endpackage

@@ hw/rtl/tip_in_if.sv @@
// Input channel: action, entry index, entry value and position beats.
interface tip_in_if import tip_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [EIDX_W-1:0]   entry_index;
  sample_t             entry_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, action, entry_index, entry_value, position, input ready);
  modport sink   (input valid, action, entry_index, entry_value, position, output ready);
endinterface

@@ hw/rtl/tip_out_if.sv @@
// Result channel: one sample per beat.
interface tip_out_if import tip_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface

@@ hw/rtl/table_interpolator.sv @@
// Top level of the wavetable lookup with truncate, linear and quadratic interpolation.
//
//   channel  dir  handshake           beat contents
//   in_ch    in   valid/ready         action, entry_index, entry_value, position
//   out_ch   out  valid/ready         result_value
//   cfg_*    in   cfg_we, no stall    cfg_index, cfg_wdata (interp_mode, table_length)
//
// Back end states per job: write IDLE; read or truncate Y0, DONE; linear adds Y1, MUL;
// quadratic adds Y2, MUL2; set by the table's one read port (a neighbor per cycle) and
// the multiply steps. The front takes a beat per cycle while the two-entry queue has room.
// Synchronous active-low reset; the table is not cleared and holds garbage until written.
// A finished result waits in the output register while the queue keeps filling.
module table_interpolator import tip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tip_in_if.sink                in_ch,
  tip_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic     q_full, q_push, q_pop, q_valid;
  tip_job_t q_job, q_head;

  tip_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_action      (in_ch.action),
    .in_entry_index (in_ch.entry_index),
    .in_entry_value (in_ch.entry_value),
    .in_position    (in_ch.position),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_job)
  );

  tip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  tip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.result_value)
  );

endmodule

@@ hw/rtl/tip_front.sv @@
// Front end: config registers, beat classification and index/fraction scaling.
module tip_front import tip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [EIDX_W-1:0]     in_entry_index,
  input  sample_t               in_entry_value,
  input  logic [POS_W-1:0]      in_position,
  input  logic                  q_full,
  output logic                  q_push,
  output tip_job_t              q_job
);

  localparam int PROD_W = ADDR_W + POS_W;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC_W);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic [LEN_W-1:0]     len_eff;
  logic [ADDR_W-1:0]    last_idx;
  logic [POS_W-1:0]     pos_c;
  logic [PROD_W-1:0]    prod;
  logic [ADDR_W-1:0]    idx;
  logic [ADDR_W:0]      idx_p1, idx_p2;
  logic [IDX_CMP_W-1:0] eidx_x, last_x;
  interp_mode_t         mode_res;

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode_nxt = cfg_wdata[MODE_W-1:0];
        CFG_LEN:  len_nxt  = cfg_wdata[LEN_W-1:0];
        default:  mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      len_r  <= LEN_W'(TABLE_DEPTH);
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
    end
  end

  always_comb begin
    priority if (mode_r[1])       mode_res = MODE_QUAD;
    else if (mode_r[0])           mode_res = MODE_LINEAR;
    else                          mode_res = MODE_TRUNC;
  end

  always_comb begin
    // A zero length acts as one, an oversized one as the full table.
    priority if (len_r == '0)               len_eff = LEN_W'(1);
    else if (len_r > LEN_W'(TABLE_DEPTH))   len_eff = LEN_W'(TABLE_DEPTH);
    else                                    len_eff = len_r;
    last_idx = ADDR_W'(len_eff - LEN_W'(1));

    pos_c  = (in_position > POS_ONE) ? POS_ONE : in_position;
    prod   = PROD_W'(last_idx) * PROD_W'(pos_c);
    idx    = prod[ADDR_W+FRAC_W-1:FRAC_W];
    idx_p1 = {1'b0, idx} + (ADDR_W+1)'(1);
    idx_p2 = {1'b0, idx} + (ADDR_W+1)'(2);

    eidx_x = IDX_CMP_W'(in_entry_index);
    last_x = IDX_CMP_W'(last_idx);

    q_job.kind  = JOB_LOOKUP;
    q_job.mode  = mode_res;
    q_job.addr0 = idx;
    q_job.addr1 = (idx_p1 > {1'b0, last_idx}) ? last_idx : idx_p1[ADDR_W-1:0];
    q_job.addr2 = (idx_p2 > {1'b0, last_idx}) ? last_idx : idx_p2[ADDR_W-1:0];
    q_job.frac  = prod[FRAC_W-1:0];
    q_job.value = in_entry_value;

    in_ready = !q_full;
    q_push   = 1'b0;
    unique case (in_action)
      ACT_WRITE: begin
        q_job.kind  = JOB_WRITE;
        q_job.addr0 = ADDR_W'(in_entry_index);
        // Drop writes beyond the store.
        q_push = in_valid && !q_full && (eidx_x < IDX_CMP_W'(TABLE_DEPTH));
      end
      ACT_READ: begin
        q_job.kind  = JOB_READ;
        q_job.addr0 = (eidx_x > last_x) ? last_idx : ADDR_W'(in_entry_index);
        q_push = in_valid && !q_full;
      end
      ACT_LOOKUP: begin
        q_push = in_valid && !q_full;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/tip_queue.sv @@
// Short job queue between front and back end.
module tip_queue import tip_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tip_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output tip_job_t head_job
);

  tip_job_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");

endmodule

@@ hw/rtl/tip_back.sv @@
// Back end: sample table, neighbor reads, interpolation and output register.
module tip_back import tip_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  tip_job_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output sample_t  out_value
);

  localparam int LIN_W = SAMPLE_W + 1 + FRAC_W + 1;
  localparam int B2_W  = SAMPLE_W + 4;
  localparam int C2_W  = SAMPLE_W + 3;
  localparam int BF_W  = B2_W + FRAC_W + 1;
  localparam int FF_W  = 2 * FRAC_W;
  localparam int CFF_W = C2_W + FF_W + 1;
  localparam int ACC_W = 62;
  localparam int R_W   = 30;
  localparam int QSH   = 2 * FRAC_W + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_Y0   = 7'b0000010,
    S_Y1   = 7'b0000100,
    S_Y2   = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_MUL2 = 7'b0100000,
    S_DONE = 7'b1000000
  } back_state_t;

  back_state_t state_r, state_nxt;
  tip_job_t    item_r, item_nxt;
  sample_t     y0_r, y0_nxt, y1_r, y1_nxt, y2_r, y2_nxt;
  logic signed [LIN_W-1:0] lin_r, lin_nxt;
  logic signed [BF_W-1:0]  bf_r, bf_nxt;
  logic [FF_W-1:0]         ff_r, ff_nxt;
  logic signed [CFF_W-1:0] cff_r, cff_nxt;
  logic    out_valid_r, out_valid_nxt;
  sample_t out_value_r, out_value_nxt;

  sample_t           table_mem [TABLE_DEPTH];
  sample_t           rdata_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  logic signed [SAMPLE_W:0]  diff;
  logic signed [B2_W-1:0]    b2;
  logic signed [C2_W-1:0]    c2;
  logic signed [FRAC_W:0]    frac_s;
  logic signed [LIN_W:0]     lin_sum;
  logic signed [ACC_W-1:0]   acc;
  logic signed [R_W-1:0]     r;
  logic                      out_free;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[q_head.addr0] <= q_head.value;
    end
    rdata_r <= table_mem[rd_addr];
  end

  always_comb begin
    frac_s = $signed({1'b0, item_r.frac});
    diff   = (SAMPLE_W+1)'(y1_r) - (SAMPLE_W+1)'(y0_r);
    b2     = (B2_W'(y1_r) <<< 2) - B2_W'(y0_r) - (B2_W'(y0_r) <<< 1) - B2_W'(y2_r);
    c2     = C2_W'(y0_r) - (C2_W'(y1_r) <<< 1) + C2_W'(y2_r);

    // Round half up, then floor.
    lin_sum = (LIN_W+1)'(lin_r) + (LIN_W+1)'(32768);
    acc     = (ACC_W'(bf_r) <<< FRAC_W) + ACC_W'(cff_r) + (ACC_W'(1) <<< (2 * FRAC_W));

    unique case (item_r.mode)
      MODE_LINEAR: r = R_W'(y0_r) + R_W'($signed(lin_sum[LIN_W:FRAC_W]));
      MODE_QUAD:   r = R_W'(y0_r) + R_W'($signed(acc[ACC_W-1:QSH]));
      default:     r = R_W'(y0_r);
    endcase
    if (item_r.kind == JOB_READ) begin
      r = R_W'(y0_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    y2_nxt        = y2_r;
    lin_nxt       = lin_r;
    bf_nxt        = bf_r;
    ff_nxt        = ff_r;
    cff_nxt       = cff_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = q_head.addr0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_head;
          if (q_head.kind == JOB_WRITE) begin
            mem_we = 1'b1;
          end else begin
            state_nxt = S_Y0;
          end
        end
      end
      S_Y0: begin
        y0_nxt  = rdata_r;
        rd_addr = item_r.addr1;
        if (item_r.kind == JOB_READ || item_r.mode == MODE_TRUNC) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_Y1;
        end
      end
      S_Y1: begin
        y1_nxt    = rdata_r;
        rd_addr   = item_r.addr2;
        state_nxt = (item_r.mode == MODE_QUAD) ? S_Y2 : S_MUL;
      end
      S_Y2: begin
        y2_nxt    = rdata_r;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        lin_nxt   = frac_s * diff;
        bf_nxt    = b2 * frac_s;
        ff_nxt    = item_r.frac * item_r.frac;
        state_nxt = (item_r.mode == MODE_QUAD) ? S_MUL2 : S_DONE;
      end
      S_MUL2: begin
        cff_nxt   = c2 * $signed({1'b0, ff_r});
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register frees up.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          priority if (r > R_W'(8388607))   out_value_nxt = sample_t'(8388607);
          else if (r < -R_W'(8388608))      out_value_nxt = sample_t'(-8388608);
          else                              out_value_nxt = r[SAMPLE_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    y0_r        <= y0_nxt;
    y1_r        <= y1_nxt;
    y2_r        <= y2_nxt;
    lin_r       <= lin_nxt;
    bf_r        <= bf_nxt;
    ff_r        <= ff_nxt;
    cff_r       <= cff_nxt;
    out_value_r <= out_value_nxt;
  end

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished result not loaded into free output register");

  a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_valid && q_head.kind != JOB_WRITE) |=> (state_r == S_Y0))
    else $error("read job did not start table access");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("job popped while back end busy");

endmodule
